[rtl/bfrx_pkg.sv]
package bfrx_pkg;

  // Payload store geometry.
  localparam int PAYLOAD_DEPTH = 64;
  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PAYLOAD_DEPTH);

  // Legal length byte range (destination, payload and checksum).
  localparam logic [7:0] MIN_LEN = 8'd2;
  localparam logic [7:0] MAX_LEN = 8'(PAYLOAD_DEPTH + 2);

  // Input operation codes.
  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  // Line error codes.
  localparam logic [1:0] LE_NONE    = 2'd0;
  localparam logic [1:0] LE_FRAMING = 2'd1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_CSUM    = 2'd2,
    ST_LEN     = 2'd3
  } status_t;

  // Receive phase of the frame parser.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RECV    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    CS_ACCEPT = 2'd0,
    CS_READ   = 2'd1,
    CS_EMIT   = 2'd2
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic load_payload;
  } bfrx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single_res;
    logic burst_res;
    logic last_rd;
  } bfrx_stat_t;

endpackage

[rtl/bfrx_ram.sv]
module bfrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bfrx_dp.sv]
module bfrx_dp
  import bfrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_tdata,
  input  logic [2:0] in_tuser,
  input  bfrx_cmd_t  cmd,
  output bfrx_stat_t stat,
  output logic [31:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  // Frame state.
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [7:0]         frame_length_r, frame_length_nxt;
  logic [7:0]         saved_source_r, saved_source_nxt;
  logic [7:0]         saved_dest_r, saved_dest_nxt;
  logic [7:0]         running_xor_r, running_xor_nxt;

  // Payload readout state.
  logic [CNT_W-1:0]   em_cnt_r, em_cnt_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;

  // Output register.
  status_t            out_st_r, out_st_nxt;
  logic [7:0]         out_src_r, out_src_nxt;
  logic [7:0]         out_dst_r, out_dst_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;

  // Decode of the incoming transfer.
  op_t              op;
  logic [7:0]       rx_byte;
  logic [1:0]       line_error;
  logic [CNT_W-1:0] pos;
  logic             is_timeout, is_frame_err, is_byte;
  logic             len_bad, is_csum, csum_ok;
  logic [7:0]       cnt_full;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] wr_off;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  status_t          single_st;

  assign op         = op_t'(in_tuser[0]);
  assign line_error = in_tuser[2:1];
  assign rx_byte    = in_tdata;
  assign pos        = byte_count_r;

  // Classify the item against the current frame position.
  always_comb begin
    is_timeout   = (op == OP_TIMEOUT);
    is_frame_err = !is_timeout && (line_error == LE_FRAMING);
    is_byte      = !is_timeout && !is_frame_err && (line_error == LE_NONE) &&
                   (phase_r != PH_DISCARD);
    len_bad      = (pos == 7'd1) && ((rx_byte < MIN_LEN) || (rx_byte > MAX_LEN));
    is_csum      = (pos >= 7'd2) &&
                   ({2'b00, pos} == ({1'b0, frame_length_r} + 9'd1));
    csum_ok      = (rx_byte == running_xor_r);
    cnt_full     = frame_length_r - 8'd2;
    cnt          = cnt_full[CNT_W-1:0];
    wr_off       = pos - 7'd3;
    ram_we       = cmd.take && is_byte && !len_bad && !is_csum && (pos >= 7'd3) &&
                   (wr_off < DEPTH_CNT);
  end

  // Status toward the controller.
  always_comb begin
    stat.single_res = is_byte && (len_bad || (is_csum && (!csum_ok || cnt == '0)));
    stat.burst_res  = is_byte && is_csum && csum_ok && (cnt != '0);
    stat.last_rd    = ((CNT_W'(rd_idx_r) + 7'd1) == em_cnt_r);
  end

  // Code of a single status result.
  always_comb begin
    priority if (len_bad) begin
      single_st = ST_LEN;
    end else if (!csum_ok) begin
      single_st = ST_CSUM;
    end else begin
      single_st = ST_EMPTY;
    end
  end

  // Next frame state.
  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    saved_source_nxt = saved_source_r;
    saved_dest_nxt   = saved_dest_r;
    running_xor_nxt  = running_xor_r;
    em_cnt_nxt       = em_cnt_r;
    rd_idx_nxt       = rd_idx_r;

    if (cmd.take) begin
      priority if (is_timeout) begin
        phase_nxt        = PH_IDLE;
        byte_count_nxt   = '0;
        frame_length_nxt = '0;
        running_xor_nxt  = '0;
      end else if (is_frame_err) begin
        phase_nxt        = PH_DISCARD;
        byte_count_nxt   = '0;
        frame_length_nxt = '0;
        running_xor_nxt  = '0;
      end else if (is_byte) begin
        phase_nxt = PH_RECV;
        if (pos == 7'd0) begin
          saved_source_nxt = rx_byte;
        end
        if (pos == 7'd1) begin
          frame_length_nxt = rx_byte;
        end
        if (pos == 7'd2) begin
          saved_dest_nxt = rx_byte;
        end
        priority if (len_bad) begin
          phase_nxt        = PH_DISCARD;
          byte_count_nxt   = '0;
          frame_length_nxt = '0;
          running_xor_nxt  = '0;
        end else if (is_csum) begin
          // Frame done: latch the payload size for readout.
          phase_nxt        = PH_IDLE;
          byte_count_nxt   = '0;
          frame_length_nxt = '0;
          running_xor_nxt  = '0;
          em_cnt_nxt       = cnt;
          rd_idx_nxt       = '0;
        end else begin
          running_xor_nxt = running_xor_r ^ rx_byte;
          byte_count_nxt  = pos + 7'd1;
        end
      end
    end

    if (cmd.load_payload) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
  end

  // Next output register contents.
  always_comb begin
    out_st_nxt   = out_st_r;
    out_src_nxt  = out_src_r;
    out_dst_nxt  = out_dst_r;
    out_data_nxt = out_data_r;
    out_cnt_nxt  = out_cnt_r;
    out_last_nxt = out_last_r;
    if (cmd.take && stat.single_res) begin
      out_st_nxt   = single_st;
      out_src_nxt  = saved_source_r;
      out_dst_nxt  = len_bad ? 8'd0 : saved_dest_r;
      out_data_nxt = 8'd0;
      out_cnt_nxt  = len_bad ? 7'd0 : cnt;
      out_last_nxt = 1'b1;
    end else if (cmd.load_payload) begin
      out_st_nxt   = ST_PAYLOAD;
      out_src_nxt  = saved_source_r;
      out_dst_nxt  = saved_dest_r;
      out_data_nxt = ram_rdata;
      out_cnt_nxt  = em_cnt_r;
      out_last_nxt = stat.last_rd;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_count_r   <= '0;
      frame_length_r <= '0;
      saved_source_r <= '0;
      saved_dest_r   <= '0;
      running_xor_r  <= '0;
      em_cnt_r       <= '0;
      rd_idx_r       <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      saved_source_r <= saved_source_nxt;
      saved_dest_r   <= saved_dest_nxt;
      running_xor_r  <= running_xor_nxt;
      em_cnt_r       <= em_cnt_nxt;
      rd_idx_r       <= rd_idx_nxt;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    out_st_r   <= out_st_nxt;
    out_src_r  <= out_src_nxt;
    out_dst_r  <= out_dst_nxt;
    out_data_r <= out_data_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  // Payload store.
  bfrx_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_off[IDX_W-1:0]),
    .wdata (rx_byte),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign out_tdata = {1'b0, out_cnt_r, out_data_r, out_dst_r, out_src_r};
  assign out_tuser = out_st_r;
  assign out_tlast = out_last_r;

endmodule

[rtl/bfrx_ctrl.sv]
module bfrx_ctrl
  import bfrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  bfrx_stat_t stat,
  output bfrx_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state and commands.
  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    cmd.take         = 1'b0;
    cmd.load_payload = 1'b0;
    unique case (state_r)
      CS_ACCEPT: begin
        in_tready = out_free;
        cmd.take  = in_tvalid && out_free;
        if (cmd.take && stat.burst_res) begin
          state_nxt = CS_READ;
        end
      end
      CS_READ: begin
        // Store read address is presented this cycle.
        state_nxt = CS_EMIT;
      end
      CS_EMIT: begin
        if (out_free) begin
          cmd.load_payload = 1'b1;
          state_nxt        = stat.last_rd ? CS_ACCEPT : CS_READ;
        end
      end
      default: begin
        state_nxt = CS_ACCEPT;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if ((cmd.take && stat.single_res) || cmd.load_payload) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/bus_frame_receiver_xor_check.sv]
// Serial-bus frame receiver with XOR checksum check.
// Input channel: one transfer per received byte or per quiet-line timeout.
// Frames are source, length, destination, payload, checksum; the checksum
// must equal the XOR of all earlier bytes of the frame.
// Result channel: a verified message gives one transfer per payload byte,
// tlast on the final one; an empty message, a checksum mismatch or a bad
// length gives a single status transfer with tlast set.
// A status result is loaded into the output register when its input
// transfer is taken. For a payload message each byte is first read from
// the payload store (registered read) and then loaded into the output
// register once that register is free; no input is taken meanwhile.
// Items that produce no result leave the controller waiting for input.
// in_tready is high when the controller is waiting for input and the output
// register is empty or being taken in that cycle.
// A stalled receiver holds the current result and the block waits.
// Reset clears the parser to idle and empties the output register; the
// payload store is not cleared, since a message reads only what it wrote.
module bus_frame_receiver_xor_check
  import bfrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic [2:0]  in_tuser,   // operation, line_error[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // source_addr, dest_addr, data_byte, payload_count, pad
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast
);

  bfrx_cmd_t  cmd;
  bfrx_stat_t stat;

  bfrx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bfrx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

[rtl/bfrx_checker.sv]
module bfrx_checker
  import bfrx_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Status results are single transfers.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_PAYLOAD) |-> out_tlast && (out_tdata[23:16] == 8'd0))
    else $error("status result without tlast or with data");

  // A length error carries neither destination nor count.
  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_LEN) |-> (out_tdata[15:8] == 8'd0) &&
    (out_tdata[30:24] == 7'd0))
    else $error("length error carries destination or count");

  // No result comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // No input is taken while a stalled result waits.
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("input taken while output stalled");

endmodule

bind bus_frame_receiver_xor_check bfrx_checker u_bfrx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
